/* rtl/lgs_pkg.sv */
// lgs_pkg: shared types and constants for the laplace gauss-seidel solver
// no dependencies; imported by laplace_gauss_seidel_solver and its bench
package lgs_pkg;

  localparam int VAL_W      = 32;  // Q16.16 grid value
  localparam int DIM_W      = 4;   // grid_rows / grid_cols register
  localparam int SWEEP_W    = 16;  // sweep limit and sweep count
  localparam int TOL_W      = 31;  // tolerance register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;  // widest register
  localparam int POS_W      = 8;   // raster position, up to 15*15 cells
  localparam int SUM_W      = 35;  // shared adder width

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS  = 2'd0,
    REG_GRID_COLS  = 2'd1,
    REG_MAX_SWEEPS = 2'd2,
    REG_TOLERANCE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_LOAD,      // taking grid values
    ST_SWEEP,     // start of a sweep
    ST_RD_NS,     // read north and south
    ST_RD_WE,     // read west and east, add north and south
    ST_RD_CTR,    // read center, add west and east
    ST_UPDATE,    // write new value, check change
    ST_SWEEP_END, // decide on another sweep
    ST_EMIT       // stream the grid out
  } lgs_state_t;

endpackage

/* rtl/laplace_gauss_seidel_solver.sv */
// laplace_gauss_seidel_solver: grid store, solve sequencer and shared adder
// depends on lgs_pkg
//
//  channel | ports                                      | beat
//  --------+--------------------------------------------+-----------------------------
//  in      | in_valid, in_stall, in_cell_value          | one grid value, raster order
//  out     | out_valid, out_stall, out_result_value,    | one solved value, raster
//          | out_last_cell, out_converged,              | order, with solve status
//          | out_sweeps_used                            |
//  cfg     | cfg_wr_en, cfg_index, cfg_data             | one register write
//
// loading stores each value taken; the last value of the grid starts the solve
// a sweep steps each interior cell through RD_NS, RD_WE, RD_CTR and UPDATE: five
// reads through the two read ports, one write and sums on the single shared adder
// results wait on out_stall; the first read is issued as the last sweep ends
// reset clears state, counts, converged flag and config; the grid store has no reset
// in_stall is high from the last value of a grid until its last result is taken
module laplace_gauss_seidel_solver #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [lgs_pkg::VAL_W-1:0]     in_cell_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lgs_pkg::VAL_W-1:0]     out_result_value,
  output logic                                 out_last_cell,
  output logic                                 out_converged,
  output logic        [lgs_pkg::SWEEP_W-1:0]   out_sweeps_used,
  input  logic                                 cfg_wr_en,
  input  logic        [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [lgs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lgs_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [6:0] MAXR = 7'(MAX_ROWS);
  localparam logic [6:0] MAXC = 7'(MAX_COLS);

  // configuration registers
  logic [DIM_W-1:0]   grid_rows_r, grid_cols_r;
  logic [SWEEP_W-1:0] max_sweeps_r;
  logic [TOL_W-1:0]   tolerance_r;

  // control
  lgs_state_t         state_r, state_nxt;
  logic [POS_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DIM_W-1:0]   row_r, row_nxt, col_r, col_nxt;
  logic [SWEEP_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic               all_within_r, all_within_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;

  // grid store
  logic [VAL_W-1:0]   grid_mem [CELLS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic               rd_en_a, rd_en_b;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic [VAL_W-1:0]   rd_a_r, rd_b_r;

  // derived sizes
  logic [DIM_W-1:0]   rows_used, cols_used;
  logic [POS_W-1:0]   total;
  logic [SWEEP_W-1:0] limit;
  logic               no_interior;

  // shared adder
  logic [SUM_W-1:0]   op_x, op_y, op_z, alu_sum;
  logic [VAL_W-1:0]   new_val;
  logic [SUM_W-1:0]   change_mag;
  logic               too_big;

  always_comb begin
    if (grid_rows_r == '0) rows_used = DIM_W'(1);
    else if ({3'b0, grid_rows_r} > MAXR) rows_used = MAXR[DIM_W-1:0];
    else rows_used = grid_rows_r;
    if (grid_cols_r == '0) cols_used = DIM_W'(1);
    else if ({3'b0, grid_cols_r} > MAXC) cols_used = MAXC[DIM_W-1:0];
    else cols_used = grid_cols_r;
  end

  assign total       = {4'b0, rows_used} * {4'b0, cols_used};
  assign limit       = (max_sweeps_r == '0) ? SWEEP_W'(1) : max_sweeps_r;
  assign no_interior = (rows_used < DIM_W'(3)) || (cols_used < DIM_W'(3));

  // new value is the four-neighbor sum shifted right by two
  assign new_val = acc_r[VAL_W+1:2];
  assign alu_sum = op_x + op_y + op_z;
  assign change_mag = alu_sum[SUM_W-1] ? (~alu_sum + SUM_W'(1)) : alu_sum;
  assign too_big    = change_mag > {4'b0, tolerance_r};

  always_comb begin
    state_nxt      = state_r;
    load_cnt_nxt   = load_cnt_r;
    pos_nxt        = pos_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    all_within_nxt = all_within_r;
    acc_nxt        = acc_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(pos_r);
    mem_wdata      = new_val;
    rd_en_a        = 1'b0;
    rd_en_b        = 1'b0;
    rd_addr_a      = AW'(pos_r);
    rd_addr_b      = AW'(pos_r + {4'b0, cols_used});
    op_x           = {{3{rd_a_r[VAL_W-1]}}, rd_a_r};
    op_y           = {{3{rd_b_r[VAL_W-1]}}, rd_b_r};
    op_z           = '0;
    in_stall       = 1'b1;
    out_valid      = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mem_we    = 1'b1;
          mem_wdata = in_cell_value;
          // a shrunk grid restarts loading at cell 0
          if (load_cnt_r >= total) begin
            mem_waddr    = '0;
            load_cnt_nxt = POS_W'(1);
          end else begin
            mem_waddr    = AW'(load_cnt_r);
            load_cnt_nxt = load_cnt_r + POS_W'(1);
          end
          if (load_cnt_nxt == total) begin
            load_cnt_nxt  = '0;
            sweep_cnt_nxt = '0;
            state_nxt     = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        sweep_cnt_nxt  = sweep_cnt_r + SWEEP_W'(1);
        all_within_nxt = 1'b1;
        row_nxt        = DIM_W'(1);
        col_nxt        = DIM_W'(1);
        pos_nxt        = {4'b0, cols_used} + POS_W'(1);
        state_nxt      = no_interior ? ST_SWEEP_END : ST_RD_NS;
      end
      ST_RD_NS: begin
        rd_en_a   = 1'b1;
        rd_en_b   = 1'b1;
        rd_addr_a = AW'(pos_r - {4'b0, cols_used});
        state_nxt = ST_RD_WE;
      end
      ST_RD_WE: begin
        acc_nxt   = alu_sum;
        rd_en_a   = 1'b1;
        rd_en_b   = 1'b1;
        rd_addr_a = AW'(pos_r - POS_W'(1));
        rd_addr_b = AW'(pos_r + POS_W'(1));
        state_nxt = ST_RD_CTR;
      end
      ST_RD_CTR: begin
        op_z      = acc_r;
        acc_nxt   = alu_sum;
        rd_en_a   = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // old minus new through the adder: x + ~new + 1
        op_y   = ~{{3{new_val[VAL_W-1]}}, new_val};
        op_z   = SUM_W'(1);
        mem_we = 1'b1;
        if (too_big) all_within_nxt = 1'b0;
        if (col_r == cols_used - DIM_W'(2)) begin
          if (row_r == rows_used - DIM_W'(2)) begin
            state_nxt = ST_SWEEP_END;
          end else begin
            row_nxt   = row_r + DIM_W'(1);
            col_nxt   = DIM_W'(1);
            pos_nxt   = pos_r + POS_W'(3);
            state_nxt = ST_RD_NS;
          end
        end else begin
          col_nxt   = col_r + DIM_W'(1);
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = ST_RD_NS;
        end
      end
      ST_SWEEP_END: begin
        if (all_within_r || (sweep_cnt_r == limit)) begin
          pos_nxt   = '0;
          rd_en_a   = 1'b1;
          rd_addr_a = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (pos_r == total - POS_W'(1)) begin
            state_nxt = ST_LOAD;
          end else begin
            pos_nxt   = pos_r + POS_W'(1);
            rd_en_a   = 1'b1;
            rd_addr_a = AW'(pos_r + POS_W'(1));
            state_nxt = ST_EMIT;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_result_value = rd_a_r;
  assign out_last_cell    = (pos_r == total - POS_W'(1));
  assign out_converged    = all_within_r;
  assign out_sweeps_used  = sweep_cnt_r;

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (rd_en_a) rd_a_r <= grid_mem[rd_addr_a];
    if (rd_en_b) rd_b_r <= grid_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      load_cnt_r   <= '0;
      sweep_cnt_r  <= '0;
      all_within_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      load_cnt_r   <= load_cnt_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      all_within_r <= all_within_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= DIM_W'(8);
      grid_cols_r  <= DIM_W'(8);
      max_sweeps_r <= SWEEP_W'(100);
      tolerance_r  <= TOL_W'(66);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_ROWS:  grid_rows_r  <= cfg_data[DIM_W-1:0];
        REG_GRID_COLS:  grid_cols_r  <= cfg_data[DIM_W-1:0];
        REG_MAX_SWEEPS: max_sweeps_r <= cfg_data[SWEEP_W-1:0];
        REG_TOLERANCE:  tolerance_r  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // no input beat while results are going out
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input taken while results pending");

  // the last result beat hands the block back to loading
  a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_cell) |=> !in_stall)
    else $error("block not ready after last result");

  // an unconverged solve must have run out of sweeps
  a_unconverged_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_converged) |-> (out_sweeps_used == limit))
    else $error("unconverged result below sweep limit");

  // every reported solve ran at least one sweep
  a_sweeps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sweeps_used != '0))
    else $error("result reports zero sweeps");

endmodule

/* tb/laplace_gauss_seidel_solver_tb.sv */
// laplace_gauss_seidel_solver_tb: self-checking bench for the gauss-seidel laplace solver
// drives whole grids through the valid/stall channel and checks every solved cell
// against a local relaxation model; depends on lgs_pkg and the solver rtl
module laplace_gauss_seidel_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lgs_pkg::*;

  localparam int MAX_DIM        = 8;
  localparam int MAX_CELLS      = MAX_DIM * MAX_DIM;
  localparam int RANDOM_VALUES  = 310;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int MAX_PRINTED    = 100;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic               last;
    logic               conv;
    logic [SWEEP_W-1:0] sweeps;
  } solved_cell_t;

  typedef enum int {FILL_WIDE, FILL_NEAR_ZERO, FILL_EXTREME, FILL_MIXED} fill_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [VAL_W-1:0]  in_cell_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [VAL_W-1:0]  out_result_value;
  logic                     out_last_cell;
  logic                     out_converged;
  logic [SWEEP_W-1:0]       out_sweeps_used;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_GRID_ROWS;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // local copy of the solver's registers and state
  logic [DIM_W-1:0]   rows_reg = 4'd8;
  logic [DIM_W-1:0]   cols_reg = 4'd8;
  logic [SWEEP_W-1:0] sweep_limit = 16'd100;
  logic [TOL_W-1:0]   tol_reg = 31'd66;
  logic [VAL_W-1:0]   grid_copy [MAX_CELLS];
  int                 cells_loaded = 0;
  logic [SWEEP_W-1:0] sweeps_done = '0;
  logic               sweep_ok = 1'b1;

  logic [VAL_W-1:0] pending_cells [$];
  solved_cell_t     solved_cells [$];

  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  int in_gap = 0;
  int out_hold = 0;
  int idle_cycles = 0;
  int err_count = 0;
  int beats_in = 0;
  int results_seen = 0;
  int grids_done = 0;
  int grids_conv = 0;

  // neighbors at one extreme, center at the other: the first sweep moves the
  // center by 2^32-1
  logic [VAL_W-1:0] extreme_cells [18] = '{
    32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_0000
  };

  laplace_gauss_seidel_solver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_value    (in_cell_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_last_cell    (out_last_cell),
    .out_converged    (out_converged),
    .out_sweeps_used  (out_sweeps_used),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int clamp_dim(input logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 4'($urandom_range(1, 4));
    if (sel < 8) return 4'($urandom_range(5, 7));
    if (sel == 8) return 4'($urandom_range(8, 15));
    return 4'd0;
  endfunction

  task automatic report_mismatch(input string what);
    // keep the log short when the block is badly off
    if (err_count < MAX_PRINTED) $display("mismatch: %s", what);
    err_count++;
  endtask

  // load one value; the last value of a grid relaxes it and queues every cell
  task automatic load_and_solve(input logic [VAL_W-1:0] value);
    int rows, cols, total, limit, at, r, c, k;
    longint sum, delta;
    logic [VAL_W-1:0] fresh;
    solved_cell_t entry;
    rows  = clamp_dim(rows_reg);
    cols  = clamp_dim(cols_reg);
    total = rows * cols;
    if (cells_loaded >= total) cells_loaded = 0;
    grid_copy[cells_loaded] = value;
    cells_loaded++;
    if (cells_loaded == total) begin
      limit = (sweep_limit == 0) ? 1 : int'(sweep_limit);
      sweeps_done = '0;
      do begin
        sweeps_done++;
        sweep_ok = 1'b1;
        for (r = 1; r < rows - 1; r++) begin
          for (c = 1; c < cols - 1; c++) begin
            at = r * cols + c;
            sum = longint'($signed(grid_copy[at - cols])) +
                  longint'($signed(grid_copy[at + cols])) +
                  longint'($signed(grid_copy[at - 1])) +
                  longint'($signed(grid_copy[at + 1]));
            // floor of the quarter, always fits back in 32 bits
            fresh = 32'(sum >>> 2);
            delta = longint'($signed(grid_copy[at])) - longint'($signed(fresh));
            if (delta < 0) delta = -delta;
            if (delta > longint'(tol_reg)) sweep_ok = 1'b0;
            grid_copy[at] = fresh;
          end
        end
      end while (!sweep_ok && sweeps_done != 16'(limit));
      cells_loaded = 0;
      for (k = 0; k < total; k++) begin
        entry.value  = grid_copy[k];
        entry.last   = (k == total - 1);
        entry.conv   = sweep_ok;
        entry.sweeps = sweeps_done;
        solved_cells.push_back(entry);
      end
    end
  endtask

  // grid value driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        load_and_solve(in_cell_value);
        beats_in++;
      end
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_cells.size() != 0) begin
        in_valid      <= 1'b1;
        in_cell_value <= pending_cells.pop_front();
        in_gap        <= in_quiet ? 0 : int'($urandom_range(0, 10));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and stall generator
  always @(posedge clk) begin : result_mon
    int draw;
    solved_cell_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen++;
      if (solved_cells.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", out_result_value));
      end else begin
        want = solved_cells.pop_front();
        if (out_result_value !== want.value || out_last_cell !== want.last ||
            out_converged !== want.conv || out_sweeps_used !== want.sweeps) begin
          report_mismatch($sformatf(
            "beat %0d: value %h last %b conv %b sweeps %0d, want %h %b %b %0d",
            results_seen, out_result_value, out_last_cell, out_converged,
            out_sweeps_used, want.value, want.last, want.conv, want.sweeps));
        end
        if (want.last) begin
          grids_done++;
          if (want.conv) grids_conv++;
        end
      end
      draw = out_quiet ? 0 : int'($urandom_range(0, 10));
      out_hold  <= draw;
      out_stall <= (draw != 0);
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  // no handshake for too long means a hung solve or a lost result
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results still due",
                 idle_cycles, solved_cells.size());
        $display("laplace_gauss_seidel_solver_tb: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_GRID_ROWS:  rows_reg = data[DIM_W-1:0];
      REG_GRID_COLS:  cols_reg = data[DIM_W-1:0];
      REG_MAX_SWEEPS: sweep_limit = data[SWEEP_W-1:0];
      REG_TOLERANCE:  tol_reg = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                          input logic [SWEEP_W-1:0] sweeps, input logic [TOL_W-1:0] tol);
    logic [CFG_DATA_W-1:0] junk;
    // unused upper data bits sometimes carry noise
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_GRID_ROWS, {junk[CFG_DATA_W-1:DIM_W], rows});
    write_reg(REG_GRID_COLS, {junk[CFG_DATA_W-1:DIM_W], cols});
    write_reg(REG_MAX_SWEEPS, {junk[CFG_DATA_W-1:SWEEP_W], sweeps});
    write_reg(REG_TOLERANCE, tol);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cells.size() != 0 || in_valid || solved_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_grid(input int count, input fill_t fill);
    logic [VAL_W-1:0] v;
    fill_t pick;
    repeat (count) begin
      pick = (fill == FILL_MIXED) ? fill_t'($urandom_range(0, 2)) : fill;
      case (pick)
        FILL_WIDE:      v = $urandom;
        FILL_NEAR_ZERO: v = 32'($urandom_range(0, 32'h1_FFFF)) - 32'h1_0000;
        default: begin
          case ($urandom_range(0, 4))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = 32'h0000_0001;
          endcase
        end
      endcase
      pending_cells.push_back(v);
    end
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0]   rows_raw, cols_raw;
    logic [SWEEP_W-1:0] sweeps;
    logic [TOL_W-1:0]   tol;
    int total, size_cap, phase, grid_values_queued;
    bit big, big_done;
    size_cap = MAX_CELLS;
    phase = 0;
    grid_values_queued = 0;
    big_done = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3, zero sweep limit acts as one, zero tolerance: stops at the limit
    set_regs(4'd3, 4'd3, 16'd0, 31'd0);
    for (int i = 0; i < 9; i++) pending_cells.push_back(extreme_cells[i]);
    wait_idle();
    // top sweep limit and tolerance: converges on the second sweep
    set_regs(4'd3, 4'd3, 16'hFFFF, 31'h7FFF_FFFF);
    for (int i = 9; i < 18; i++) pending_cells.push_back(extreme_cells[i]);
    wait_idle();
    // zero sizes clamp to a single cell with no interior
    set_regs(4'd0, 4'd0, 16'd1, 31'd0);
    pending_cells.push_back(32'h8000_0000);
    wait_idle();
    // grid shrinks under a partial load: loading starts over at cell zero
    set_regs(4'd2, 4'd3, 16'd100, 31'd66);
    queue_grid(4, FILL_WIDE);
    wait_idle();
    set_regs(4'd2, 4'd1, 16'd100, 31'd66);
    queue_grid(2, FILL_WIDE);
    wait_idle();

    while (grid_values_queued < RANDOM_VALUES) begin
      big = !big_done && size_cap == MAX_CELLS && phase >= 2;
      if (big) begin
        rows_raw = 4'd15;
        cols_raw = 4'd8;
        big_done = 1'b1;
      end else begin
        do begin
          rows_raw = pick_dim();
          cols_raw = pick_dim();
        end while (clamp_dim(rows_raw) * clamp_dim(cols_raw) > size_cap);
      end
      total = clamp_dim(rows_raw) * clamp_dim(cols_raw);
      case ($urandom_range(0, 4))
        0:       tol = '0;
        1:       tol = 31'($urandom_range(1, 200));
        2:       tol = 31'($urandom_range(32'h1000, 32'h10_0000));
        3:       tol = 31'($urandom);
        default: tol = 31'h7FFF_FFFF;
      endcase
      // long limits only where a sweep is short, the top one only with a loose tolerance
      case ($urandom_range(0, 5))
        0:       sweeps = 16'd0;
        1:       sweeps = 16'd1;
        2:       sweeps = 16'($urandom_range(2, 8));
        3:       sweeps = 16'($urandom_range(9, 120));
        4:       sweeps = (tol >= 31'h1_0000 && total <= 16) ? 16'hFFFF : 16'd100;
        default: sweeps = (total <= 16) ? 16'($urandom_range(121, 300)) : 16'd60;
      endcase
      if (big) sweeps = 16'($urandom_range(1, 120));
      set_regs(rows_raw, cols_raw, sweeps, tol);
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      repeat (big ? 1 : $urandom_range(1, 3)) begin
        queue_grid(total, fill_t'($urandom_range(0, 3)));
        grid_values_queued += total;
      end
      // a broken grid now and then; the next size fits in it so loading restarts
      if (total > 1 && $urandom_range(0, 4) == 0) begin
        size_cap = $urandom_range(1, total - 1);
        queue_grid(size_cap, fill_t'($urandom_range(0, 3)));
      end else begin
        size_cap = MAX_CELLS;
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (solved_cells.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", solved_cells.size()));
    $display("run: %0d grid values in, %0d result beats checked over %0d phases",
             beats_in, results_seen, phase + 5);
    $display("run: %0d grids solved, %0d converged, %0d stopped at the sweep limit",
             grids_done, grids_conv, grids_done - grids_conv);
    if (err_count == 0) begin
      $display("laplace_gauss_seidel_solver_tb: clean");
    end else begin
      $display("laplace_gauss_seidel_solver_tb: errors");
    end
    $finish;
  end

endmodule
